/* hdl/html_entity_escaper_core_assert.svh */
// Assertion macros for the checker of the escaper core.
`ifndef HTML_ENTITY_ESCAPER_CORE_ASSERT_SVH
`define HTML_ENTITY_ESCAPER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define HEE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hee assertion failed: same-cycle rule");

// Next-cycle implication, sampled on clk and switched off during rst.
`define HEE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hee assertion failed: next-cycle rule");

`endif

/* hdl/hee_pkg.sv */
// Package: types, codes and the entity text table of the escaper core.
package hee_pkg;

  // Bytes that take a named entity.
  localparam logic [7:0] CHR_QUOT = 8'h22;
  localparam logic [7:0] CHR_AMP  = 8'h26;
  localparam logic [7:0] CHR_LT   = 8'h3C;
  localparam logic [7:0] CHR_GT   = 8'h3E;

  // Upper three bits shared by the Latin-1 range 0xA0 to 0xBF.
  localparam logic [2:0] LATIN_TOP = 3'b101;

  // Entity indexes into the text table.
  localparam logic [5:0] ENT_QUOT       = 6'd0;
  localparam logic [5:0] ENT_AMP        = 6'd1;
  localparam logic [5:0] ENT_LT         = 6'd2;
  localparam logic [5:0] ENT_GT         = 6'd3;
  localparam logic [5:0] ENT_LATIN_BASE = 6'd4;

  // Queue between the front and back parts.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // One classified request as it travels through the queue.
  typedef struct packed {
    logic       is_ent;
    logic [5:0] idx;
    logic [7:0] raw;
  } qent_t;

  // Write side of the queue.
  typedef struct packed {
    logic  push;
    qent_t entry;
  } qpush_t;

  // Read side of the queue.
  typedef struct packed {
    logic  valid;
    qent_t entry;
  } qhead_t;

  // Entity text, first character in the highest used byte.
  typedef struct packed {
    logic [2:0]  len_m1;
    logic [63:0] text;
  } ent_t;

  // Entity text table, one arm per entity.
  function automatic ent_t ent_lookup(input logic [5:0] idx);
    ent_t r;
    unique case (idx)
      ENT_QUOT: r = '{3'd5, 64'("&quot;")};
      ENT_AMP:  r = '{3'd4, 64'("&amp;")};
      ENT_LT:   r = '{3'd3, 64'("&lt;")};
      ENT_GT:   r = '{3'd3, 64'("&gt;")};
      6'd4:  r = '{3'd5, 64'("&nbsp;")};
      6'd5:  r = '{3'd6, 64'("&iexcl;")};
      6'd6:  r = '{3'd5, 64'("&cent;")};
      6'd7:  r = '{3'd6, 64'("&pound;")};
      6'd8:  r = '{3'd7, 64'("&curren;")};
      6'd9:  r = '{3'd4, 64'("&yen;")};
      6'd10: r = '{3'd7, 64'("&brvbar;")};
      6'd11: r = '{3'd5, 64'("&sect;")};
      6'd12: r = '{3'd4, 64'("&uml;")};
      6'd13: r = '{3'd5, 64'("&copy;")};
      6'd14: r = '{3'd5, 64'("&ordf;")};
      6'd15: r = '{3'd6, 64'("&laquo;")};
      6'd16: r = '{3'd4, 64'("&not;")};
      6'd17: r = '{3'd4, 64'("&shy;")};
      6'd18: r = '{3'd4, 64'("&reg;")};
      6'd19: r = '{3'd5, 64'("&macr;")};
      6'd20: r = '{3'd4, 64'("&deg;")};
      6'd21: r = '{3'd7, 64'("&plusmn;")};
      6'd22: r = '{3'd5, 64'("&sup2;")};
      6'd23: r = '{3'd5, 64'("&sup3;")};
      6'd24: r = '{3'd6, 64'("&acute;")};
      6'd25: r = '{3'd6, 64'("&micro;")};
      6'd26: r = '{3'd5, 64'("&para;")};
      6'd27: r = '{3'd7, 64'("&middot;")};
      6'd28: r = '{3'd6, 64'("&cedil;")};
      6'd29: r = '{3'd5, 64'("&sup1;")};
      6'd30: r = '{3'd5, 64'("&ordm;")};
      6'd31: r = '{3'd6, 64'("&raquo;")};
      6'd32: r = '{3'd7, 64'("&frac14;")};
      6'd33: r = '{3'd7, 64'("&frac12;")};
      6'd34: r = '{3'd7, 64'("&frac34;")};
      6'd35: r = '{3'd7, 64'("&iquest;")};
      default: r = '{3'd0, 64'd0};
    endcase
    return r;
  endfunction

endpackage

/* hdl/hee_front.sv */
// Front part: takes input bytes and classifies them for the queue.
module hee_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 q_full,
  output hee_pkg::qpush_t      q_push
);

  // A request is taken whenever the queue has room.
  assign in_ready = !q_full;

  // Classify the byte into pass-through or an entity index.
  always_comb begin
    q_push.push         = in_valid && !q_full;
    q_push.entry.raw    = in_byte;
    q_push.entry.is_ent = 1'b1;
    q_push.entry.idx    = hee_pkg::ENT_QUOT;
    unique case (in_byte)
      hee_pkg::CHR_QUOT: q_push.entry.idx = hee_pkg::ENT_QUOT;
      hee_pkg::CHR_AMP:  q_push.entry.idx = hee_pkg::ENT_AMP;
      hee_pkg::CHR_LT:   q_push.entry.idx = hee_pkg::ENT_LT;
      hee_pkg::CHR_GT:   q_push.entry.idx = hee_pkg::ENT_GT;
      default: begin
        if (in_byte[7:5] == hee_pkg::LATIN_TOP) begin
          q_push.entry.idx = hee_pkg::ENT_LATIN_BASE + {1'b0, in_byte[4:0]};
        end else begin
          q_push.entry.is_ent = 1'b0;
        end
      end
    endcase
  end

endmodule

/* hdl/hee_queue.sv */
// Short queue of classified requests between the front and back parts.
module hee_queue (
  input  logic            clk,
  input  logic            rst,
  input  hee_pkg::qpush_t q_push,
  output logic            q_full,
  output hee_pkg::qhead_t q_head,
  input  logic            q_pop
);

  hee_pkg::qent_t                 entries [hee_pkg::QDEPTH];
  logic [hee_pkg::QPTR_W-1:0]     wr_ptr;
  logic [hee_pkg::QPTR_W-1:0]     rd_ptr;
  logic [hee_pkg::QCNT_W-1:0]     count;
  logic                           do_push;
  logic                           do_pop;

  assign q_full       = (count == hee_pkg::QCNT_W'(hee_pkg::QDEPTH));
  assign do_push      = q_push.push && !q_full;
  assign do_pop       = q_pop && (count != '0);
  assign q_head.valid = (count != '0);
  assign q_head.entry = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + hee_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + hee_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + hee_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - hee_pkg::QCNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= q_push.entry;
    end
  end

endmodule

/* hdl/hee_back.sv */
// Back part: spells out each queued request one character per cycle while the output is not stalled.
module hee_back (
  input  logic            clk,
  input  logic            rst,
  input  hee_pkg::qhead_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_char,
  output logic            run_last
);

  hee_pkg::ent_t ent;
  logic [2:0]    pos;
  logic [7:0]    char_next;
  logic          last_next;
  logic          load;

  // Character at the current position of the head request.
  always_comb begin
    ent = hee_pkg::ent_lookup(q_head.entry.idx);
    if (q_head.entry.is_ent) begin
      char_next = ent.text[{ent.len_m1 - pos, 3'b000} +: 8];
      last_next = (pos == ent.len_m1);
    end else begin
      char_next = q_head.entry.raw;
      last_next = 1'b1;
    end
  end

  // The output register refills whenever a request waits and it is empty or being drained.
  assign load  = q_head.valid && (!out_valid || out_ready);
  assign q_pop = load && last_next;

  // Output valid and position within the run.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (!out_valid || out_ready) begin
        out_valid <= q_head.valid;
      end
      if (load) begin
        pos <= last_next ? 3'd0 : pos + 3'd1;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= char_next;
      run_last <= last_next;
    end
  end

endmodule

/* hdl/html_entity_escaper_core.sv */
// Top level of the HTML entity escaper: front, queue and back parts.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   in_byte
//   out      source     out_valid / out_ready out_char, run_last
//
// Each request yields one character per cycle while out_ready is high: a plain
// byte yields one character, an entity as many as it has (four to eight).
// The back part's single output register sets that pace.
// A four-entry queue lets the input keep taking requests while an entity
// is spelled out or the output is stalled; in_ready drops when it is full.
// Reset empties the queue and the output register; no clearing pass.
module html_entity_escaper_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       run_last
);

  hee_pkg::qpush_t q_push;
  hee_pkg::qhead_t q_head;
  logic            q_full;
  logic            q_pop;

  // Classification of incoming requests.
  hee_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .q_push   (q_push)
  );

  // Decoupling queue.
  hee_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .q_full (q_full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  // Character generation.
  hee_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .run_last  (run_last)
  );

endmodule

/* hdl/hee_checker.sv */
// Port-level checker for the escaper core, bound to the top level.
`include "html_entity_escaper_core_assert.svh"

module hee_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       run_last
);

  logic out_stall;

  assign out_stall = out_valid && !out_ready;

  // A stalled result holds its value.
  `HEE_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_char) && $stable(run_last))

  // Inside an entity the next character is ready at once.
  `HEE_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !run_last, out_valid)

  // Only entity characters can be non-final, and none of them is zero.
  `HEE_ASSERT_NOW(a_mid_nonzero, out_valid && !run_last, out_char != 8'h00)

  // A semicolon always closes a run.
  `HEE_ASSERT_NOW(a_semi_last, out_valid && out_char == 8'h3B, run_last)

endmodule

bind html_entity_escaper_core hee_checker u_hee_checker (.*);
